// File: rtl/fpfa_pkg.sv
// Shared constants, codes and types of the fixed partition fit allocator.
package fpfa_pkg;

  // Table geometry.
  localparam int NUM_PARTS = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = $clog2(NUM_PARTS);
  localparam int CNT_W     = $clog2(NUM_PARTS + 1);

  // Port field widths.
  localparam int CMD_W    = 1;
  localparam int PART_W   = 4;
  localparam int AMT_W    = 16;
  localparam int POL_W    = 2;
  localparam int BCNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  // Compare width: wide enough for both a stored size and a request.
  localparam int WIDE_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  // Fit policies; the unused code behaves as first fit.
  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(NUM_PARTS);

  // Controller to datapath.
  typedef struct packed {
    logic load;    // write a partition size, mark it free
    logic start;   // latch request, clear the search
    logic step;    // issue one table read / compare
    logic commit;  // publish result, mark pick occupied
  } fpfa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;  // all entries compared
    logic out_free;   // result register can take a beat
  } fpfa_sts_t;

endpackage

// File: rtl/fpfa_if.sv
// Valid/ready channel interfaces: input items, results and register writes.
interface fpfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpfa_pkg::CMD_W-1:0]    command;
  logic [fpfa_pkg::PART_W-1:0]   part_index;
  logic [fpfa_pkg::AMT_W-1:0]    amount;

  modport source (output valid, output command, output part_index, output amount,
                  input ready);
  modport sink   (input valid, input command, input part_index, input amount,
                  output ready);
endinterface

interface fpfa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [fpfa_pkg::PART_W-1:0]   chosen_part;

  modport source (output valid, output granted, output chosen_part, input ready);
  modport sink   (input valid, input granted, input chosen_part, output ready);
endinterface

interface fpfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpfa_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [fpfa_pkg::CFG_DAT_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// File: rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed partition fit allocator (first, best, worst fit).
// Load beats: no result; the next beat is taken the following cycle.
// Allocate beats, n active partitions: n table reads, compare drain, then commit once the
//   result register is free; no new beat is taken until that commit.
// Results sit in an output register; a new beat is accepted while one waits.
// Reset (rst_n low, synchronous): all partitions free, first fit, block_count 16.
module fixed_partition_fit_allocator (
  input  logic              clk,
  input  logic              rst_n,
  fpfa_in_if.sink           in_if,
  fpfa_out_if.source        out_if,
  fpfa_cfg_if.sink          cfg_if
);

  fpfa_pkg::fpfa_cmd_t cmd;
  fpfa_pkg::fpfa_sts_t sts;

  // Register writes are always taken; software must only write while idle, unchecked here.
  assign cfg_if.ready = 1'b1;

  // Sequencer: idle -> scan over the active partitions -> commit.
  fpfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_command (in_if.command),
    .in_ready   (in_if.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Size table, occupied marks, running best pick and the result register.
  fpfa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_part_index   (in_if.part_index),
    .in_amount       (in_if.amount),
    .cfg_we          (cfg_if.valid),
    .cfg_reg_index   (cfg_if.reg_index),
    .cfg_wdata       (cfg_if.wdata),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_granted     (out_if.granted),
    .out_chosen_part (out_if.chosen_part)
  );

endmodule

// File: rtl/fpfa_ctrl.sv
// Controller state machine: accept, scan sequencing and result commit.
module fpfa_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [fpfa_pkg::CMD_W-1:0]   in_command,
  output logic                         in_ready,
  input  fpfa_pkg::fpfa_sts_t          sts,
  output fpfa_pkg::fpfa_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == fpfa_pkg::CMD_ALLOC) begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/fpfa_dp.sv
// Datapath: size table, occupied marks, scan compare, config and result registers.
module fpfa_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fpfa_pkg::fpfa_cmd_t           cmd,
  output fpfa_pkg::fpfa_sts_t           sts,
  input  logic [fpfa_pkg::PART_W-1:0]   in_part_index,
  input  logic [fpfa_pkg::AMT_W-1:0]    in_amount,
  input  logic                          cfg_we,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0] cfg_reg_index,
  input  logic [fpfa_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_granted,
  output logic [fpfa_pkg::PART_W-1:0]   out_chosen_part
);

  // Size table: one write port (load), one registered read port (scan).
  logic [fpfa_pkg::SIZE_BITS-1:0] size_mem [fpfa_pkg::NUM_PARTS];
  logic [fpfa_pkg::SIZE_BITS-1:0] rd_data_r;

  logic [fpfa_pkg::NUM_PARTS-1:0] occ_r, occ_nxt;
  logic [fpfa_pkg::POL_W-1:0]     policy_r;
  logic [fpfa_pkg::BCNT_W-1:0]    bcount_r;

  logic [fpfa_pkg::WIDE_W-1:0]    amt_r;
  logic [fpfa_pkg::CNT_W-1:0]     cnt_r, n_r;
  logic                           cmp_v_r;
  logic [fpfa_pkg::IDX_W-1:0]     cmp_idx_r;
  logic                           found_r;
  logic [fpfa_pkg::IDX_W-1:0]     pick_r;
  logic [fpfa_pkg::WIDE_W-1:0]    pick_left_r;

  logic                           out_valid_r;
  logic                           granted_r;
  logic [fpfa_pkg::PART_W-1:0]    chosen_r;

  logic [fpfa_pkg::WIDE_W-1:0]    load_w, rd_w, left;
  logic                           load_ok, issue, cand, take;
  logic [fpfa_pkg::CNT_W-1:0]     n_clamp;

  assign load_w  = fpfa_pkg::WIDE_W'(in_amount);
  assign load_ok = (fpfa_pkg::WIDE_W'(in_part_index) < fpfa_pkg::WIDE_W'(fpfa_pkg::NUM_PARTS));
  assign issue   = cmd.step && (cnt_r < n_r);
  assign n_clamp = (fpfa_pkg::WIDE_W'(bcount_r) > fpfa_pkg::WIDE_W'(fpfa_pkg::NUM_PARTS)) ?
                   fpfa_pkg::CNT_W'(fpfa_pkg::NUM_PARTS) : fpfa_pkg::CNT_W'(bcount_r);

  // Compare stage on the registered read.
  assign rd_w = fpfa_pkg::WIDE_W'(rd_data_r);
  assign left = rd_w - amt_r;
  assign cand = cmp_v_r && !occ_r[cmp_idx_r] && (rd_w >= amt_r);
  always_comb begin
    take = 1'b0;
    if (cand) begin
      if (!found_r)                              take = 1'b1;
      else if (policy_r == fpfa_pkg::POL_BEST)   take = (left < pick_left_r);
      else if (policy_r == fpfa_pkg::POL_WORST)  take = (left > pick_left_r);
    end
  end

  assign sts.scan_done = (cnt_r >= n_r) && !cmp_v_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok)
      size_mem[in_part_index[fpfa_pkg::IDX_W-1:0]] <= load_w[fpfa_pkg::SIZE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (issue) rd_data_r <= size_mem[cnt_r[fpfa_pkg::IDX_W-1:0]];
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.load && load_ok) occ_nxt[in_part_index[fpfa_pkg::IDX_W-1:0]] = 1'b0;
    if (cmd.commit && found_r) occ_nxt[pick_r] = 1'b1;
  end

  // Control-like state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      policy_r    <= fpfa_pkg::POL_FIRST;
      bcount_r    <= fpfa_pkg::BCNT_RESET;
      cnt_r       <= '0;
      n_r         <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_index)
          fpfa_pkg::REG_FIT_POLICY:  policy_r <= cfg_wdata[fpfa_pkg::POL_W-1:0];
          fpfa_pkg::REG_BLOCK_COUNT: bcount_r <= cfg_wdata[fpfa_pkg::BCNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        cnt_r   <= '0;
        n_r     <= n_clamp;
        cmp_v_r <= 1'b0;
        found_r <= 1'b0;
      end else begin
        if (issue) cnt_r <= cnt_r + 1'b1;
        cmp_v_r <= issue;
        if (take) found_r <= 1'b1;
      end
      if (cmd.commit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.start) amt_r <= fpfa_pkg::WIDE_W'(in_amount);
    if (issue)     cmp_idx_r <= cnt_r[fpfa_pkg::IDX_W-1:0];
    if (take) begin
      pick_r      <= cmp_idx_r;
      pick_left_r <= left;
    end
    if (cmd.commit) begin
      granted_r <= found_r;
      chosen_r  <= found_r ? fpfa_pkg::PART_W'(pick_r) : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_granted     = granted_r;
  assign out_chosen_part = chosen_r;

endmodule

// File: rtl/fpfa_checker.sv
// Port-level checker for the allocator, bound to the top level.
module fpfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [fpfa_pkg::CMD_W-1:0]   in_command,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_granted,
  input logic [fpfa_pkg::PART_W-1:0]  out_chosen_part
);

  // A stalled result beat stays.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_granted) && $stable(out_chosen_part))
    else $error("result payload changed while stalled");

  // A refused request reports partition zero.
  a_deny_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_chosen_part == '0)
    else $error("denied result carries a partition index");

  // An accepted allocate occupies the block for the scan.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == fpfa_pkg::CMD_ALLOC |=> !in_ready)
    else $error("input taken during a scan");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_command      (in_if.command),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_granted     (out_if.granted),
  .out_chosen_part (out_if.chosen_part)
);

// File: tb/sv/fpfa_checker.sv
// Allocation predictor and result checker for the fixed partition fit allocator.
module fpfa_scoreboard (
  input  logic clk,
  input  logic rst_n,
  fpfa_in_if   in_mon,
  fpfa_out_if  out_mon,
  fpfa_cfg_if  cfg_mon,
  output int   fail_count,
  output int   grants_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpfa_pkg::*;

  typedef struct packed {
    logic              granted;
    logic [PART_W-1:0] chosen_part;
  } grant_t;

  // Shadow of the partition table and the live settings.
  logic [SIZE_BITS-1:0] part_size [NUM_PARTS];
  logic [NUM_PARTS-1:0] part_busy;
  logic [POL_W-1:0]     policy;
  logic [BCNT_W-1:0]    blk_count;
  grant_t               grant_q [$];
  int                   mismatches = 0;
  int                   queued = 0;

  assign fail_count = mismatches;
  assign grants_due = queued;

  // Picks a free partition for the request and marks it busy.
  function automatic grant_t allocate_fit(input logic [AMT_W-1:0] request);
    int                active;
    int                pick;
    logic              found;
    logic [WIDE_W-1:0] left;
    logic [WIDE_W-1:0] pick_left;
    grant_t            g;
    active    = (blk_count > NUM_PARTS) ? NUM_PARTS : int'(blk_count);
    found     = 1'b0;
    pick      = 0;
    pick_left = '0;
    for (int j = 0; j < active; j++) begin
      if (!part_busy[j] && WIDE_W'(part_size[j]) >= WIDE_W'(request)) begin
        left = WIDE_W'(part_size[j]) - WIDE_W'(request);
        if (!found) begin
          found     = 1'b1;
          pick      = j;
          pick_left = left;
        end else if (policy == POL_BEST && left < pick_left) begin
          pick      = j;
          pick_left = left;
        end else if (policy == POL_WORST && left > pick_left) begin
          pick      = j;
          pick_left = left;
        end
      end
    end
    if (found) part_busy[pick] = 1'b1;
    g.granted     = found;
    g.chosen_part = found ? PART_W'(pick) : '0;
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t exp_g;
    if (!rst_n) begin
      for (int i = 0; i < NUM_PARTS; i++) part_size[i] = '0;
      part_busy = '0;
      policy    = POL_FIRST;
      blk_count = BCNT_RESET;
      grant_q.delete();
    end else begin
      // Results first: a result never answers a beat taken at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (grant_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat granted=%0b chosen_part=%0d",
                   $time, out_mon.granted, out_mon.chosen_part);
        end else begin
          exp_g = grant_q.pop_front();
          if (out_mon.granted !== exp_g.granted) begin
            mismatches++;
            $display("%0t: granted mismatch expected=%0b actual=%0b",
                     $time, exp_g.granted, out_mon.granted);
          end
          if (out_mon.chosen_part !== exp_g.chosen_part) begin
            mismatches++;
            $display("%0t: chosen_part mismatch expected=%0d actual=%0d",
                     $time, exp_g.chosen_part, out_mon.chosen_part);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          REG_FIT_POLICY:  policy = cfg_mon.wdata[POL_W-1:0];
          REG_BLOCK_COUNT: blk_count = cfg_mon.wdata[BCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD) begin
          part_size[in_mon.part_index] = in_mon.amount;
          part_busy[in_mon.part_index] = 1'b0;
        end else begin
          grant_q.push_back(allocate_fit(in_mon.amount));
        end
      end
    end
    queued <= grant_q.size();
  end

endmodule

// File: tb/sv/tb_fixed_partition_fit_allocator.sv
// Testbench top: stimulus, output backpressure and verdict for the partition allocator.
module tb_fixed_partition_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import fpfa_pkg::*;

  // Watchdog limit, settle time after the last grant, result hold-off length and gap percentage.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 25;
  localparam int HOLD_CYCLES   = 300;
  localparam int GAP_PCT       = 37;

  // Codes the package does not name: the spare policy and the unused register slots.
  localparam logic [POL_W-1:0]     POL_SPARE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  fpfa_in_if  in_ch ();
  fpfa_out_if out_ch ();
  fpfa_cfg_if cfg_ch ();

  int   fail_count;
  int   grants_due;
  int   cycle_count;
  int   in_gap_pct  = GAP_PCT;
  int   out_gap_pct = GAP_PCT;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;

  // Sizes last loaded per partition, used only to aim requests at real sizes.
  logic [SIZE_BITS-1:0] loaded_size [NUM_PARTS];

  always #2 clk = ~clk;

  fixed_partition_fit_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  fpfa_scoreboard u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .grants_due (grants_due)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random backpressure, plus a long hold-off on request.
  // The hold is counted here so the sender keeps pushing beats meanwhile.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done    <= 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_gap_pct);
      end
    end
  end

  // One input beat, after a random gap. valid stays high on exit so that
  // back-to-back beats never lower and raise it in the same step.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [PART_W-1:0] idx,
                           input logic [AMT_W-1:0] amt);
    while ($urandom_range(99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.part_index <= idx;
    in_ch.amount     <= amt;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_LOAD) loaded_size[idx] = amt;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait out every expected grant, then let a trailing
  // load or scan finish before touching the registers.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (grants_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random beat: loads draw often from a small pool of sizes so ties show up
  // under best and worst fit; requests mostly aim at a size already loaded
  // (exact fit, a little under, one over) so grants and refusals both occur.
  task automatic random_item();
    int                 r;
    int                 j;
    logic [AMT_W-1:0]   amt;
    j = $urandom_range(NUM_PARTS - 1);
    r = $urandom_range(99);
    if ($urandom_range(99) < 45) begin
      if (r < 40)      amt = AMT_W'(64 * $urandom_range(1, 4));
      else if (r < 55) amt = AMT_W'($urandom_range(1023));
      else if (r < 92) amt = AMT_W'($urandom);
      else             amt = (r < 96) ? '0 : '1;
      send_item(CMD_LOAD, PART_W'(j), amt);
    end else begin
      if (r < 35)      amt = loaded_size[j];
      else if (r < 55) amt = (loaded_size[j] > 16) ?
                             loaded_size[j] - AMT_W'($urandom_range(16)) : '0;
      else if (r < 65) amt = loaded_size[j] + 1'b1;
      else if (r < 80) amt = AMT_W'($urandom_range(300));
      else if (r < 95) amt = AMT_W'($urandom);
      else             amt = (r < 98) ? '0 : '1;
      // part_index is a don't-care on allocate; toggle it anyway
      send_item(CMD_ALLOC, PART_W'($urandom), amt);
    end
  endtask

  // Reprogram while idle, then run a batch. Upper policy bits are junk that
  // the block must mask off.
  task automatic run_phase(input logic [POL_W-1:0] pol, input logic [BCNT_W-1:0] cnt,
                           input int n);
    settle();
    write_reg(REG_FIT_POLICY, {(CFG_DAT_W - POL_W)'($urandom), pol});
    write_reg(REG_BLOCK_COUNT, CFG_DAT_W'(cnt));
    repeat (n) random_item();
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_LOAD;
    in_ch.part_index <= '0;
    in_ch.amount     <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_FIT_POLICY;
    cfg_ch.wdata     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings (first fit, 16 partitions).
    // Load every partition before any scan so no entry is read unwritten:
    // size 0 at the bottom, full scale at the top, equal pairs between.
    for (int i = 0; i < NUM_PARTS; i++) begin
      send_item(CMD_LOAD, PART_W'(i),
                (i == 0) ? '0 :
                (i == NUM_PARTS - 1) ? '1 : AMT_W'(100 * ((i + 1) / 2)));
    end
    send_item(CMD_ALLOC, '0, '0);              // zero request fits the empty partition
    send_item(CMD_ALLOC, '1, '1);              // full-scale request takes the top
    send_item(CMD_ALLOC, '0, '1);              // nothing left that large
    send_item(CMD_ALLOC, '0, AMT_W'(150));     // skips the 100s, first 200
    send_item(CMD_LOAD, PART_W'(NUM_PARTS - 1), '1);  // reload frees an occupied one
    send_item(CMD_ALLOC, '0, '1);              // so it is granted again
    send_item(CMD_ALLOC, '0, AMT_W'(1));

    // Random part, walking through policies and active counts.
    run_phase(POL_BEST, 5'd16, 150);
    run_phase(POL_WORST, 5'd16, 150);
    run_phase(POL_SPARE, 5'd16, 100);          // spare policy acts as first fit
    run_phase(POL_FIRST, 5'd0, 60);            // no active partitions
    run_phase(POL_BEST, 5'd17, 150);           // count clamps to the table size
    run_phase(POL_WORST, 5'd31, 150);
    run_phase(POL_BEST, 5'd1, 80);

    // Writes to unused register slots must change nothing.
    settle();
    write_reg(REG_SPARE_2, CFG_DAT_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DAT_W'($urandom));
    repeat (20) random_item();

    run_phase(POL_FIRST, 5'd8, 130);
    run_phase(POL_WORST, 5'd5, 120);

    // Full-rate stretch: no gaps on either side.
    in_gap_pct  = 0;
    out_gap_pct = 0;
    run_phase(POL_BEST, 5'd16, 200);
    in_gap_pct  = GAP_PCT;
    out_gap_pct = GAP_PCT;

    // Long result hold-off while beats keep coming: the output register
    // fills and the input side has to stall.
    run_phase(POL_FIRST, 5'd16, 20);
    hold_req <= 1'b1;
    repeat (180) random_item();

    run_phase(POL_WORST, 5'd12, 200);
    run_phase(POL_BEST, 5'd16, 200);

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
